// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the gait scheduler. Both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/gpss_pkg.sv =====
package gpss_pkg;

	localparam int unsigned LEG_COUNT = 4;
	localparam int unsigned LEG_W = 2;
	localparam int unsigned MAX_WINDOWS_DEF = 8;
	localparam int unsigned TICK_W = 32;
	localparam int unsigned SPAN_W = 16;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [2:0] REG_GAIT_MODE = 3'd0;
	localparam logic [2:0] REG_PERIOD = 3'd1;
	localparam logic [2:0] REG_STANCE = 3'd2;
	localparam logic [2:0] REG_HORIZON = 3'd3;
	localparam logic [2:0] REG_START = 3'd4;

	localparam logic [MODE_W-1:0] RST_GAIT_MODE = 2'd1;
	localparam logic [SPAN_W-1:0] RST_PERIOD = 16'd1000;
	localparam logic [SPAN_W-1:0] RST_STANCE = 16'd500;
	localparam logic [SPAN_W-1:0] RST_HORIZON = 16'd800;
	localparam logic [TICK_W-1:0] RST_START = 32'd0;

	localparam logic [LEG_W-1:0] LEG_FL = 2'd0;
	localparam logic [LEG_W-1:0] LEG_FR = 2'd1;
	localparam logic [LEG_W-1:0] LEG_RL = 2'd2;
	localparam logic [LEG_W-1:0] LEG_RR = 2'd3;

	typedef enum logic [MODE_W-1:0] {
		GAIT_STAND = 2'd0,
		GAIT_TROT = 2'd1,
		GAIT_BOUND = 2'd2
	} gait_mode_t;

	// Effective settings: period never zero, stance never above period.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SPAN_W-1:0] period;
		logic [SPAN_W-1:0] stance;
		logic [SPAN_W-1:0] horizon;
		logic [TICK_W-1:0] start;
	} cfg_t;

	typedef struct packed {
		logic [TICK_W-1:0] now;
		logic [SPAN_W-1:0] phase;
	} job_t;

	function automatic logic leg_offset(logic [MODE_W-1:0] mode, logic [LEG_W-1:0] leg);
		logic res;
		res = 1'b0;
		if (mode == GAIT_TROT) begin
			res = (leg == LEG_FR) || (leg == LEG_RL);
		end else if (mode == GAIT_BOUND) begin
			res = (leg == LEG_FL) || (leg == LEG_FR);
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/gpss_front.sv =====
module gpss_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [gpss_pkg::TICK_W-1:0]  now_tick,
	input  gpss_pkg::cfg_t               cfg,
	output logic                         push_valid,
	input  logic                         push_ready,
	output gpss_pkg::job_t               push_job
);

	localparam int unsigned STEP_W = $clog2(gpss_pkg::TICK_W);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_FIX, F_PUSH} fstate_t;

	fstate_t                          state_q;
	logic [gpss_pkg::TICK_W-1:0]      now_q;
	logic [gpss_pkg::TICK_W-1:0]      mag_q;
	logic [gpss_pkg::SPAN_W-1:0]      rem_q;
	logic                             neg_q;
	logic [STEP_W-1:0]                step_q;
	gpss_pkg::job_t                   job_q;

	logic [gpss_pkg::TICK_W-1:0]      diff;
	logic [gpss_pkg::TICK_W-1:0]      mag_in;
	logic [gpss_pkg::SPAN_W:0]        rem_shift;
	logic [gpss_pkg::SPAN_W:0]        rem_next;

	always_comb begin
		diff = now_tick - cfg.start;
		mag_in = diff[gpss_pkg::TICK_W-1] ? (~diff + 1'b1) : diff;
		rem_shift = {rem_q, mag_q[gpss_pkg::TICK_W-1]};
		if (rem_shift >= {1'b0, cfg.period}) begin
			rem_next = rem_shift - {1'b0, cfg.period};
		end else begin
			rem_next = rem_shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						now_q <= now_tick;
						mag_q <= mag_in;
						neg_q <= diff[gpss_pkg::TICK_W-1];
						rem_q <= '0;
						step_q <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q <= rem_next[gpss_pkg::SPAN_W-1:0];
					mag_q <= mag_q << 1;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(gpss_pkg::TICK_W - 1)) begin
						state_q <= F_FIX;
					end
				end
				F_FIX: begin
					job_q.now <= now_q;
					if (neg_q && (rem_q != '0)) begin
						job_q.phase <= cfg.period - rem_q;
					end else begin
						job_q.phase <= rem_q;
					end
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_job = job_q;

endmodule

// ===== hw/rtl/gpss_queue.sv =====
module gpss_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  gpss_pkg::job_t  push_job,
	output logic            pop_valid,
	input  logic            pop_ready,
	output gpss_pkg::job_t  pop_job
);

	localparam int unsigned DEPTH = gpss_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	gpss_pkg::job_t      mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/gpss_back.sv =====
module gpss_back #(
	parameter int unsigned MAX_WINDOWS = gpss_pkg::MAX_WINDOWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  gpss_pkg::job_t               pop_job,
	input  gpss_pkg::cfg_t               cfg,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gpss_pkg::LEG_W-1:0]   leg,
	output logic                         in_contact,
	output logic                         window_valid,
	output logic [gpss_pkg::TICK_W-1:0]  swing_begin,
	output logic [gpss_pkg::TICK_W-1:0]  swing_finish,
	output logic                         windows_dropped,
	output logic                         last_of_leg,
	output logic                         last
);

	localparam int unsigned CNT_W = $clog2(MAX_WINDOWS + 1);
	localparam int unsigned CUR_W = gpss_pkg::SPAN_W + 2;
	localparam int unsigned CUT_W = CUR_W + CNT_W;

	typedef enum logic [1:0] {B_IDLE, B_PHASE, B_SETUP, B_EMIT} bstate_t;

	bstate_t                        state_q;
	gpss_pkg::job_t                 job_q;
	logic [gpss_pkg::LEG_W-1:0]     leg_q;
	logic [gpss_pkg::SPAN_W-1:0]    lp_q;
	logic                           contact_q;
	logic                           ongoing_q;
	logic                           none_q;
	logic                           dropped_q;
	logic [CUR_W-1:0]               cur_q;
	logic [CNT_W-1:0]               cnt_q;

	logic                           out_valid_q;
	logic [gpss_pkg::LEG_W-1:0]     leg_out_q;
	logic                           contact_out_q;
	logic                           wvalid_q;
	logic [gpss_pkg::TICK_W-1:0]    begin_q;
	logic [gpss_pkg::TICK_W-1:0]    finish_q;
	logic                           dropped_out_q;
	logic                           last_leg_q;
	logic                           last_q;

	logic [gpss_pkg::SPAN_W:0]      lp_sum;
	logic [gpss_pkg::SPAN_W:0]      lp_wrap;
	logic                           contact;
	logic [CUR_W-1:0]               c0;
	logic [CUT_W-1:0]               cutoff;
	logic [CUR_W-1:0]               end_raw;
	logic [CUR_W-1:0]               end_clip;
	logic [CUR_W-1:0]               next_cur;
	logic [CUR_W-1:0]               horizon_ext;
	logic                           has_next;
	logic                           fire;
	logic                           leg_done;
	logic [gpss_pkg::TICK_W-1:0]    begin_val;
	logic [gpss_pkg::TICK_W-1:0]    finish_val;

	always_comb begin
		horizon_ext = CUR_W'(cfg.horizon);
		lp_sum = {1'b0, job_q.phase};
		if (gpss_pkg::leg_offset(cfg.mode, leg_q)) begin
			lp_sum = {1'b0, job_q.phase} + {2'b00, cfg.period[gpss_pkg::SPAN_W-1:1]};
		end
		lp_wrap = (lp_sum >= {1'b0, cfg.period}) ? lp_sum - {1'b0, cfg.period} : lp_sum;

		contact = (lp_q < cfg.stance);
		if (contact) begin
			c0 = CUR_W'(cfg.stance) - CUR_W'(lp_q);
			cutoff = CUT_W'(c0) + CUT_W'(MAX_WINDOWS) * CUT_W'(cfg.period);
		end else begin
			c0 = CUR_W'(cfg.period) - CUR_W'(lp_q) + CUR_W'(cfg.stance);
			cutoff = CUT_W'(c0) + CUT_W'(MAX_WINDOWS - 1) * CUT_W'(cfg.period);
		end

		end_raw = cur_q + CUR_W'(cfg.period) - CUR_W'(cfg.stance);
		end_clip = (end_raw < horizon_ext) ? end_raw : horizon_ext;
		next_cur = ongoing_q ? cur_q : cur_q + CUR_W'(cfg.period);
		has_next = (CNT_W'(cnt_q + 1'b1) < CNT_W'(MAX_WINDOWS)) && (next_cur < horizon_ext);
		leg_done = none_q || !has_next;
		fire = (state_q == B_EMIT) && (!out_valid_q || out_ready);

		if (none_q) begin
			begin_val = '0;
			finish_val = '0;
		end else if (ongoing_q) begin
			begin_val = job_q.now - gpss_pkg::TICK_W'(lp_q - cfg.stance);
			finish_val = job_q.now + gpss_pkg::TICK_W'(cfg.period - lp_q);
		end else begin
			begin_val = job_q.now + gpss_pkg::TICK_W'(cur_q);
			finish_val = job_q.now + gpss_pkg::TICK_W'(end_clip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						job_q <= pop_job;
						leg_q <= '0;
						state_q <= B_PHASE;
					end
				end
				B_PHASE: begin
					lp_q <= lp_wrap[gpss_pkg::SPAN_W-1:0];
					state_q <= B_SETUP;
				end
				B_SETUP: begin
					contact_q <= contact;
					ongoing_q <= !contact;
					none_q <= contact && (c0 >= horizon_ext);
					dropped_q <= (cutoff < CUT_W'(cfg.horizon));
					cur_q <= c0;
					cnt_q <= '0;
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (fire) begin
						out_valid_q <= 1'b1;
						leg_out_q <= leg_q;
						contact_out_q <= contact_q;
						wvalid_q <= !none_q;
						begin_q <= begin_val;
						finish_q <= finish_val;
						dropped_out_q <= dropped_q;
						last_leg_q <= leg_done;
						last_q <= leg_done && (leg_q == gpss_pkg::LEG_W'(gpss_pkg::LEG_COUNT - 1));
						if (leg_done) begin
							if (leg_q == gpss_pkg::LEG_W'(gpss_pkg::LEG_COUNT - 1)) begin
								state_q <= B_IDLE;
							end else begin
								leg_q <= leg_q + 1'b1;
								state_q <= B_PHASE;
							end
						end else begin
							ongoing_q <= 1'b0;
							cur_q <= next_cur;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign pop_ready = (state_q == B_IDLE);
	assign out_valid = out_valid_q;
	assign leg = leg_out_q;
	assign in_contact = contact_out_q;
	assign window_valid = wvalid_q;
	assign swing_begin = begin_q;
	assign swing_finish = finish_q;
	assign windows_dropped = dropped_out_q;
	assign last_of_leg = last_leg_q;
	assign last = last_q;

endmodule

// ===== hw/rtl/gait_phase_swing_scheduler_unit.sv =====
// Gait scheduler: for each now_tick beat it emits, leg by leg in the order FL, FR, RL, RR,
// between four and 4*MAX_WINDOWS_PER_LEG result beats, at most one per cycle.
// The front end takes a beat and then works out the gait phase, mostly a bit-serial
// remainder that retires one bit of the 32-bit elapsed time per cycle; in_ready is low
// meanwhile. A two-entry queue holds finished phases, so the next beat's phase is worked out
// while the back end still emits. The back end takes a phase from the queue, passes each
// leg through a phase and a setup state, and emits one result per cycle while out_ready is
// high. Registers must be written over APB only while the block is idle; the block itself
// does not enforce this, and there is no clearing pass after reset.
`include "assert_macros.svh"

module gait_phase_swing_scheduler_unit #(
	parameter int unsigned MAX_WINDOWS_PER_LEG = gpss_pkg::MAX_WINDOWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gpss_pkg::ADDR_W-1:0]  paddr,
	input  logic [gpss_pkg::DATA_W-1:0]  pwdata,
	output logic [gpss_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [gpss_pkg::TICK_W-1:0]  now_tick,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gpss_pkg::LEG_W-1:0]   leg,
	output logic                         in_contact,
	output logic                         window_valid,
	output logic [gpss_pkg::TICK_W-1:0]  swing_begin,
	output logic [gpss_pkg::TICK_W-1:0]  swing_finish,
	output logic                         windows_dropped,
	output logic                         last_of_leg,
	output logic                         last
);

	logic [gpss_pkg::MODE_W-1:0]  mode_q;
	logic [gpss_pkg::SPAN_W-1:0]  period_q;
	logic [gpss_pkg::SPAN_W-1:0]  stance_q;
	logic [gpss_pkg::SPAN_W-1:0]  horizon_q;
	logic [gpss_pkg::TICK_W-1:0]  start_q;
	logic [2:0]                   reg_idx;
	logic                         wr_en;
	logic [gpss_pkg::SPAN_W-1:0]  period_eff;
	gpss_pkg::cfg_t               cfg;
	logic                         push_valid;
	logic                         push_ready;
	gpss_pkg::job_t               push_job;
	logic                         pop_valid;
	logic                         pop_ready;
	gpss_pkg::job_t               pop_job;

	assign reg_idx = paddr[gpss_pkg::ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= gpss_pkg::RST_GAIT_MODE;
			period_q <= gpss_pkg::RST_PERIOD;
			stance_q <= gpss_pkg::RST_STANCE;
			horizon_q <= gpss_pkg::RST_HORIZON;
			start_q <= gpss_pkg::RST_START;
		end else if (wr_en) begin
			unique case (reg_idx)
				gpss_pkg::REG_GAIT_MODE: mode_q <= pwdata[gpss_pkg::MODE_W-1:0];
				gpss_pkg::REG_PERIOD: period_q <= pwdata[gpss_pkg::SPAN_W-1:0];
				gpss_pkg::REG_STANCE: stance_q <= pwdata[gpss_pkg::SPAN_W-1:0];
				gpss_pkg::REG_HORIZON: horizon_q <= pwdata[gpss_pkg::SPAN_W-1:0];
				gpss_pkg::REG_START: start_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			gpss_pkg::REG_GAIT_MODE: prdata = gpss_pkg::DATA_W'(mode_q);
			gpss_pkg::REG_PERIOD: prdata = gpss_pkg::DATA_W'(period_q);
			gpss_pkg::REG_STANCE: prdata = gpss_pkg::DATA_W'(stance_q);
			gpss_pkg::REG_HORIZON: prdata = gpss_pkg::DATA_W'(horizon_q);
			gpss_pkg::REG_START: prdata = start_q;
			default: prdata = '0;
		endcase
	end

	always_comb begin
		period_eff = (period_q == '0) ? gpss_pkg::SPAN_W'(1) : period_q;
		cfg.mode = mode_q;
		cfg.period = period_eff;
		cfg.stance = (stance_q > period_eff) ? period_eff : stance_q;
		cfg.horizon = horizon_q;
		cfg.start = start_q;
	end

	gpss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.now_tick   (now_tick),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	gpss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	gpss_back #(
		.MAX_WINDOWS (MAX_WINDOWS_PER_LEG)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_job         (pop_job),
		.cfg             (cfg),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.leg             (leg),
		.in_contact      (in_contact),
		.window_valid    (window_valid),
		.swing_begin     (swing_begin),
		.swing_finish    (swing_finish),
		.windows_dropped (windows_dropped),
		.last_of_leg     (last_of_leg),
		.last            (last)
	);

	`ASSERT_SAME(a_last_ends_leg, out_valid && last, last_of_leg && (leg == gpss_pkg::LEG_RR), "final beat must close the last leg")
	`ASSERT_SAME(a_empty_single, out_valid && !window_valid, last_of_leg, "a leg without windows gives one beat")
	`ASSERT_SAME(a_empty_zero, out_valid && !window_valid, (swing_begin == '0) && (swing_finish == '0), "empty window must read zero")
	`ASSERT_NEXT(a_front_busy, in_valid && in_ready, !in_ready, "front end must be busy after taking a beat")

endmodule

// ===== test/tb_gait_phase_swing_scheduler_unit.sv =====
`timescale 1ns / 100ps

module tb_gait_phase_swing_scheduler_unit;
	import gpss_pkg::*;

	typedef logic [TICK_W-1:0] tick_t;

	typedef struct packed {
		logic [LEG_W-1:0] leg;
		logic in_contact;
		logic window_valid;
		tick_t swing_begin;
		tick_t swing_finish;
		logic windows_dropped;
		logic last_of_leg;
		logic last;
	} swing_beat_t;

	localparam logic [MODE_W-1:0] GAIT_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned PHASE_ITEMS = 30;
	localparam int unsigned RANDOM_PHASES = 12;

	class swing_scoreboard;
		logic [MODE_W-1:0] mode;
		logic [SPAN_W-1:0] period;
		logic [SPAN_W-1:0] stance;
		logic [SPAN_W-1:0] horizon;
		tick_t start;
		swing_beat_t swing_beats_due[$];
		int unsigned errors;
		int unsigned beat_no;

		function new();
			mode = RST_GAIT_MODE;
			period = RST_PERIOD;
			stance = RST_STANCE;
			horizon = RST_HORIZON;
			start = RST_START;
			errors = 0;
			beat_no = 0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) begin
				$display("mismatch: %s", msg);
			end
		endtask

		function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_GAIT_MODE: begin
					mode = val[MODE_W-1:0];
				end
				REG_PERIOD: begin
					period = val[SPAN_W-1:0];
				end
				REG_STANCE: begin
					stance = val[SPAN_W-1:0];
				end
				REG_HORIZON: begin
					horizon = val[SPAN_W-1:0];
				end
				REG_START: begin
					start = val[TICK_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// Works out the swing windows of all four legs for one accepted tick.
		function void note_tick(tick_t now);
			swing_beat_t beats[$];
			swing_beat_t b;
			longint p, s, h, d, ph, lp, cursor, e;
			longint begins[MAX_WINDOWS_DEF];
			longint ends[MAX_WINDOWS_DEF];
			int cnt;
			bit dropped, contact, shifted;
			logic [LEG_W-1:0] lg;
			tick_t diff;
			p = (period == 0) ? 1 : longint'(period);
			s = longint'(stance);
			h = longint'(horizon);
			if (s > p) begin
				s = p;
			end
			diff = now - start;
			d = longint'($signed(diff));
			ph = d % p;
			if (ph < 0) begin
				ph += p;
			end
			for (int l = 0; l < LEG_COUNT; l++) begin
				lg = LEG_W'(l);
				shifted = (mode == GAIT_TROT && (lg == LEG_FR || lg == LEG_RL)) ||
					(mode == GAIT_BOUND && (lg == LEG_FL || lg == LEG_FR));
				lp = ph + (shifted ? p / 2 : 0);
				if (lp >= p) begin
					lp -= p;
				end
				contact = lp < s;
				cnt = 0;
				dropped = 0;
				if (!contact) begin
					begins[0] = s - lp;
					ends[0] = p - lp;
					cnt = 1;
					cursor = p - lp + s;
				end else begin
					cursor = s - lp;
				end
				while (cursor < h) begin
					e = cursor + p - s;
					if (cnt >= MAX_WINDOWS_DEF) begin
						dropped = 1;
						break;
					end
					begins[cnt] = cursor;
					ends[cnt] = (e < h) ? e : h;
					cnt++;
					cursor += p;
				end
				b = '0;
				b.leg = lg;
				b.in_contact = contact;
				b.windows_dropped = dropped;
				if (cnt == 0) begin
					b.last_of_leg = 1'b1;
					beats.push_back(b);
				end else begin
					for (int k = 0; k < cnt; k++) begin
						b.window_valid = 1'b1;
						b.swing_begin = tick_t'(longint'(now) + begins[k]);
						b.swing_finish = tick_t'(longint'(now) + ends[k]);
						b.last_of_leg = (k == cnt - 1);
						beats.push_back(b);
					end
				end
			end
			beats[beats.size() - 1].last = 1'b1;
			foreach (beats[i]) begin
				swing_beats_due.push_back(beats[i]);
			end
		endfunction

		task cmp(string name, logic [TICK_W-1:0] got, logic [TICK_W-1:0] want);
			if (got !== want) begin
				report($sformatf("beat %0d %s: got %0h, expected %0h", beat_no, name, got, want));
			end
		endtask

		task check_beat(swing_beat_t got);
			swing_beat_t want;
			if (swing_beats_due.size() == 0) begin
				report($sformatf("beat %0d arrived with nothing expected: %p", beat_no, got));
			end else begin
				want = swing_beats_due.pop_front();
				cmp("leg", TICK_W'(got.leg), TICK_W'(want.leg));
				cmp("in_contact", TICK_W'(got.in_contact), TICK_W'(want.in_contact));
				cmp("window_valid", TICK_W'(got.window_valid), TICK_W'(want.window_valid));
				cmp("swing_begin", got.swing_begin, want.swing_begin);
				cmp("swing_finish", got.swing_finish, want.swing_finish);
				cmp("windows_dropped", TICK_W'(got.windows_dropped),
					TICK_W'(want.windows_dropped));
				cmp("last_of_leg", TICK_W'(got.last_of_leg), TICK_W'(want.last_of_leg));
				cmp("last", TICK_W'(got.last), TICK_W'(want.last));
			end
			beat_no++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	tick_t now_tick = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [LEG_W-1:0] leg;
	logic in_contact;
	logic window_valid;
	tick_t swing_begin;
	tick_t swing_finish;
	logic windows_dropped;
	logic last_of_leg;
	logic last;

	swing_scoreboard sb;
	swing_beat_t seen_beat;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned phase_no = 0;
	int unsigned cycles = 0;

	gait_phase_swing_scheduler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.now_tick(now_tick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.leg(leg),
		.in_contact(in_contact),
		.window_valid(window_valid),
		.swing_begin(swing_begin),
		.swing_finish(swing_finish),
		.windows_dropped(windows_dropped),
		.last_of_leg(last_of_leg),
		.last(last)
	);

	always #1 clk = ~clk;

	assign seen_beat = {leg, in_contact, window_valid, swing_begin, swing_finish,
		windows_dropped, last_of_leg, last};

	always @(negedge clk) begin
		if (arst_n) begin
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_beat(seen_beat);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		paddr = {idx, 2'b00};
		pwdata = val;
		pwrite = 1'b1;
		psel = 1'b1;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		@(negedge clk);
		penable = 1'b0;
	endtask

	task automatic drive_ticks(input tick_t ticks[$]);
		foreach (ticks[i]) begin
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
			in_valid = 1'b1;
			now_tick = ticks[i];
			do @(posedge clk); while (!in_ready);
			sb.note_tick(ticks[i]);
			@(negedge clk);
		end
		in_valid = 1'b0;
	endtask

	task automatic run_phase(input bit write_cfg, input logic [MODE_W-1:0] m,
			input logic [SPAN_W-1:0] per, input logic [SPAN_W-1:0] st,
			input logic [SPAN_W-1:0] hor, input tick_t st_tick, input tick_t ticks[$]);
		while (sb.swing_beats_due.size() != 0) begin
			@(negedge clk);
		end
		if (write_cfg) begin
			apb_write(REG_GAIT_MODE, DATA_W'(m));
			apb_write(REG_PERIOD, DATA_W'(per));
			apb_write(REG_STANCE, DATA_W'(st));
			apb_write(REG_HORIZON, DATA_W'(hor));
			apb_write(REG_START, DATA_W'(st_tick));
			psel = 1'b0;
			pwrite = 1'b0;
		end
		case (phase_no % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 87;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 87;
			end
			default: begin
				send_idle_pct = 32;
				recv_stall_pct = 32;
			end
		endcase
		phase_no++;
		drive_ticks(ticks);
	endtask

	initial begin
		tick_t ticks[$];
		tick_t t, st_tick;
		logic [MODE_W-1:0] m;
		logic [SPAN_W-1:0] per, st, hor;
		longint span;
		int lim;
		sb = new();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		ticks = '{32'd0, 32'd499, 32'd500, 32'd999, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF};
		run_phase(1'b0, RST_GAIT_MODE, RST_PERIOD, RST_STANCE, RST_HORIZON, RST_START, ticks);
		ticks = '{32'hFFFF_FFFF, 32'h0000_7FFF, 32'h1234_5678};
		run_phase(1'b1, GAIT_BOUND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, ticks);
		ticks = '{32'd0, 32'd1, 32'hFFFF_FFFE};
		run_phase(1'b1, GAIT_STAND, 16'd2, 16'd1, 16'hFFFF, 32'd0, ticks);
		ticks = '{32'h8000_0000, 32'd0};
		run_phase(1'b1, GAIT_UNUSED, 16'd0, 16'd0, 16'd0, 32'h8000_0000, ticks);
		ticks = '{32'd5, 32'd6};
		run_phase(1'b1, GAIT_TROT, 16'd1, 16'd5, 16'd3, 32'd0, ticks);
		ticks = '{32'd0, 32'd50};
		run_phase(1'b1, GAIT_TROT, 16'd100, 16'd0, 16'd0, 32'd0, ticks);
		ticks = '{32'd7, 32'hFFFF_FFFF};
		run_phase(1'b1, GAIT_BOUND, 16'd3, 16'd2, 16'hFFFF, 32'd0, ticks);
		ticks = '{32'h8000_0000};
		run_phase(1'b1, GAIT_TROT, 16'hFFFF, 16'd0, 16'hFFFF, 32'd0, ticks);

		for (int n = 0; n < RANDOM_PHASES; n++) begin
			m = ($urandom_range(9) == 0) ? GAIT_UNUSED : MODE_W'($urandom_range(2));
			case ($urandom_range(5))
				0: per = SPAN_W'($urandom_range(2, 8));
				1: per = SPAN_W'($urandom_range(9, 200));
				2: per = SPAN_W'($urandom_range(201, 5000));
				3: per = SPAN_W'($urandom_range(2, 65535));
				4: per = 16'hFFFF;
				default: per = SPAN_W'($urandom_range(1));
			endcase
			case ($urandom_range(3))
				0: st = '0;
				1: st = SPAN_W'($urandom_range(0, per));
				2: st = per;
				default: st = SPAN_W'($urandom_range(65535));
			endcase
			lim = 4 * int'(per) + 4;
			if (lim > 65535) begin
				lim = 65535;
			end
			case ($urandom_range(3))
				0: hor = '0;
				1: hor = 16'hFFFF;
				2: hor = SPAN_W'($urandom_range(0, lim));
				default: hor = SPAN_W'($urandom_range(65535));
			endcase
			st_tick = $urandom;
			span = longint'(per) + 2;
			ticks.delete();
			repeat (PHASE_ITEMS) begin
				case ($urandom_range(9))
					0, 1: t = $urandom;
					2: t = st_tick + 32'h8000_0000 + tick_t'($urandom_range(8)) - 32'd4;
					default: t = st_tick +
						tick_t'(longint'($urandom_range(0, 6 * span)) - 3 * span);
				endcase
				ticks.push_back(t);
			end
			run_phase(1'b1, m, per, st, hor, st_tick, ticks);
		end

		while (sb.swing_beats_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (64) @(negedge clk);
		if (sb.swing_beats_due.size() != 0) begin
			sb.report($sformatf("%0d beats never arrived", sb.swing_beats_due.size()));
		end
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/gpss_pkg.sv
hw/rtl/gpss_front.sv
hw/rtl/gpss_queue.sv
hw/rtl/gpss_back.sv
hw/rtl/gait_phase_swing_scheduler_unit.sv
test/tb_gait_phase_swing_scheduler_unit.sv
